### design/assert_macros.svh
// Assertion macros used by the checker file pds_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped during reset.
`define PDS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped during reset.
`define PDS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/pds_pkg.sv
// Types and constants of the PLL divider search.
package pds_pkg;

   localparam int TARGET_W   = 31;
   localparam int REF_W      = 27;
   localparam int FREQ_W     = 31;
   localparam int FREF_W     = 26;
   localparam int FOUT_W     = 27;
   localparam int PRE_IDX_W  = 5;
   localparam int FB_IDX_W   = 9;
   localparam int POST_IDX_W = 2;
   localparam int OSC_W      = 2;

   // Restoring divider: one quotient bit per step.
   localparam int DIV_STEPS  = REF_W;
   localparam int DIV_CNT_W  = 5;

   localparam logic [FREF_W-1:0] FREF_LO = 26'd800000;
   localparam logic [FREF_W-1:0] FREF_HI = 26'd8000000;
   localparam logic [27:0]       FVCO_LO = 28'd100000000;
   localparam logic [27:0]       FVCO_HI = 28'd200000000;
   localparam logic [FOUT_W-1:0] FOUT_HI = 27'd80000000;
   localparam logic [FREQ_W-1:0] NO_FREQ = 31'h7FFF_FFFF;
   localparam logic [REF_W-1:0]  FRC_RESET = 27'd7370000;

   // x / 32000 = ((x >> 8) * RECIP_125) >> RECIP_SHIFT, exact for x < 2^28.
   localparam logic [20:0] RECIP_125   = 21'd1073742;
   localparam int          RECIP_SHIFT = 27;

   localparam logic [POST_IDX_W-1:0] POST_DIV2     = 2'd0;
   localparam logic [POST_IDX_W-1:0] POST_DIV4     = 2'd1;
   localparam logic [POST_IDX_W-1:0] POST_DIV32000 = 2'd2;
   localparam logic [POST_IDX_W-1:0] POST_DIV8     = 2'd3;

   localparam logic [OSC_W-1:0] OSC_FRC     = 2'd0;
   localparam logic [OSC_W-1:0] OSC_FRC_PLL = 2'd1;
   localparam logic [OSC_W-1:0] OSC_PRI     = 2'd2;
   localparam logic [OSC_W-1:0] OSC_PRI_PLL = 2'd3;

   typedef struct packed {
      logic                  start;
      logic [REF_W-1:0]      ref_freq;
      logic [TARGET_W-1:0]   target_freq;
   } scan_cmd_type;

   typedef struct packed {
      logic                  done;
      logic                  found;
      logic [FREQ_W-1:0]     best_freq;
      logic [PRE_IDX_W-1:0]  pre_index;
      logic [FB_IDX_W-1:0]   fb_index;
      logic [POST_IDX_W-1:0] post_index;
   } scan_res_type;

endpackage

### design/pll_divider_search.sv
// Top level of the PLL divider search: handshakes, FRC register, result register.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid/req_ready   | target, base frequency, source
//   rsp     | out       | rsp_valid/rsp_ready   | best frequency, indices, osc, found
//   csr     | in        | csr_valid/csr_ready   | FRC frequency
//
// A direct match goes from accept to T_EMIT and raises rsp_valid once the output
// register is free. A PLL search runs the serial divider for each prescaler and,
// for each prescaler whose reference lands in range, issues FB_COUNT * 4
// candidates through the evaluation pipeline, one candidate per cycle.
// req_ready is low from accept until the result sits in the output register.
// A stalled rsp holds the next result in the sequencer. Reset is synchronous.
module pll_divider_search #(
   parameter int PRE_COUNT = 32,
   parameter int FB_COUNT  = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pds_pkg::TARGET_W-1:0]   req_target_freq,
   input  logic [pds_pkg::REF_W-1:0]      req_base_freq,
   input  logic                           req_source,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pds_pkg::FREQ_W-1:0]     rsp_best_freq,
   output logic [pds_pkg::PRE_IDX_W-1:0]  rsp_pre_index,
   output logic [pds_pkg::FB_IDX_W-1:0]   rsp_fb_index,
   output logic [pds_pkg::POST_IDX_W-1:0] rsp_post_index,
   output logic [pds_pkg::OSC_W-1:0]      rsp_osc_select,
   output logic                           rsp_found,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pds_pkg::REF_W-1:0]      csr_frc_freq
);

   typedef enum logic [1:0] {
      T_IDLE, T_SCAN, T_EMIT
   } state_type;

   state_type                      state_ff, state_in;
   logic [pds_pkg::REF_W-1:0]      frc_ff, frc_in;
   logic [pds_pkg::REF_W-1:0]      ref_ff, ref_in;
   logic                           direct_ff, direct_in;
   logic                           source_ff, source_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pds_pkg::FREQ_W-1:0]     best_ff, best_in;
   logic [pds_pkg::PRE_IDX_W-1:0]  pre_ff, pre_in;
   logic [pds_pkg::FB_IDX_W-1:0]   fb_ff, fb_in;
   logic [pds_pkg::POST_IDX_W-1:0] post_ff, post_in;
   logic [pds_pkg::OSC_W-1:0]      osc_ff, osc_in;
   logic                           found_ff, found_in;

   logic                           accept;
   logic [pds_pkg::REF_W-1:0]      ref_sel;
   logic                           match;
   logic                           out_free;
   pds_pkg::scan_cmd_type          scan_cmd;
   pds_pkg::scan_res_type          scan_res;

   assign req_ready = (state_ff == T_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign ref_sel   = req_source ? req_base_freq : frc_ff;
   assign match     = ({4'b0, ref_sel} == req_target_freq);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign scan_cmd.start       = accept && !match;
   assign scan_cmd.ref_freq    = ref_sel;
   assign scan_cmd.target_freq = req_target_freq;

   pds_scan #(
      .PRE_COUNT(PRE_COUNT),
      .FB_COUNT (FB_COUNT)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (scan_cmd),
      .res   (scan_res)
   );

   always_comb begin
      state_in     = state_ff;
      frc_in       = frc_ff;
      ref_in       = ref_ff;
      direct_in    = direct_ff;
      source_in    = source_ff;
      rsp_valid_in = rsp_valid_ff;
      best_in      = best_ff;
      pre_in       = pre_ff;
      fb_in        = fb_ff;
      post_in      = post_ff;
      osc_in       = osc_ff;
      found_in     = found_ff;
      if (csr_valid && csr_ready) begin
         frc_in = csr_frc_freq;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               ref_in    = ref_sel;
               direct_in = match;
               source_in = req_source;
               state_in  = match ? T_EMIT : T_SCAN;
            end
         end
         T_SCAN: begin
            if (scan_res.done) begin
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (direct_ff) begin
                  best_in  = {4'b0, ref_ff};
                  pre_in   = '0;
                  fb_in    = '0;
                  post_in  = '0;
                  osc_in   = source_ff ? pds_pkg::OSC_PRI : pds_pkg::OSC_FRC;
                  found_in = 1'b1;
               end else begin
                  best_in  = scan_res.best_freq;
                  pre_in   = scan_res.pre_index;
                  fb_in    = scan_res.fb_index;
                  post_in  = scan_res.post_index;
                  osc_in   = source_ff ? pds_pkg::OSC_PRI_PLL : pds_pkg::OSC_FRC_PLL;
                  found_in = scan_res.found;
               end
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         frc_ff       <= pds_pkg::FRC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frc_ff       <= frc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ref_ff    <= ref_in;
      direct_ff <= direct_in;
      source_ff <= source_in;
      best_ff   <= best_in;
      pre_ff    <= pre_in;
      fb_ff     <= fb_in;
      post_ff   <= post_in;
      osc_ff    <= osc_in;
      found_ff  <= found_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_freq  = best_ff;
   assign rsp_pre_index  = pre_ff;
   assign rsp_fb_index   = fb_ff;
   assign rsp_post_index = post_ff;
   assign rsp_osc_select = osc_ff;
   assign rsp_found      = found_ff;

endmodule

### design/pds_divider.sv
// Restoring divider for the prescaled reference, one quotient bit per cycle.
module pds_divider #(
   parameter int DIV_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pds_pkg::REF_W-1:0]  dividend,
   input  logic [DIV_W-1:0]           divisor,
   output logic                       done,
   output logic [pds_pkg::FREF_W-1:0] quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [pds_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]              div_ff, div_in;
   logic [DIV_W-1:0]              rem_ff, rem_in;
   logic [pds_pkg::REF_W-1:0]     quo_ff, quo_in;
   logic [DIV_W:0]                shifted;
   logic [DIV_W+1:0]              trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[pds_pkg::REF_W-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // keep the trial difference when it does not borrow
         if (!trial[DIV_W+1]) begin
            rem_in = trial[DIV_W-1:0];
         end else begin
            rem_in = shifted[DIV_W-1:0];
         end
         quo_in = {quo_ff[pds_pkg::REF_W-2:0], ~trial[DIV_W+1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pds_pkg::DIV_CNT_W'(pds_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[pds_pkg::FREF_W-1:0];

endmodule

### design/pds_scan.sv
// Scan sequencer with the pipelined candidate evaluation unit.
module pds_scan #(
   parameter int PRE_COUNT = 32,
   parameter int FB_COUNT  = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pds_pkg::scan_cmd_type cmd,
   output pds_pkg::scan_res_type res
);

   localparam int PW = (PRE_COUNT > 1) ? $clog2(PRE_COUNT) : 1;
   localparam int FW = (FB_COUNT > 1) ? $clog2(FB_COUNT) : 1;
   localparam int DW = $clog2(PRE_COUNT + 2);
   localparam int MW = $clog2(FB_COUNT + 2);
   localparam int VW = pds_pkg::FREF_W + MW;

   typedef enum logic [2:0] {
      S_IDLE, S_DIVGO, S_DIV, S_SCAN, S_DRAIN, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [pds_pkg::REF_W-1:0]      ref_ff, ref_in;
   logic [pds_pkg::TARGET_W-1:0]   target_ff, target_in;
   logic [PW-1:0]                  p_ff, p_in;
   logic [FW-1:0]                  f_ff, f_in;
   logic [pds_pkg::POST_IDX_W-1:0] q_ff, q_in;
   logic [pds_pkg::FREF_W-1:0]     fref_ff, fref_in;
   logic [VW-1:0]                  fvco_ff, fvco_in;

   // stage A: candidate issued
   logic                           a_valid_ff, a_valid_in;
   logic [VW-1:0]                  a_fvco_ff;
   logic [PW-1:0]                  a_p_ff;
   logic [FW-1:0]                  a_f_ff;
   logic [pds_pkg::POST_IDX_W-1:0] a_q_ff;

   // stage B: output frequency known
   logic                           b_valid_ff, b_valid_in;
   logic                           b_ok_ff, b_ok_in;
   logic [pds_pkg::FOUT_W-1:0]     b_fout_ff, b_fout_in;
   logic [PW-1:0]                  b_p_ff;
   logic [FW-1:0]                  b_f_ff;
   logic [pds_pkg::POST_IDX_W-1:0] b_q_ff;

   // best so far
   logic                           found_ff, found_in;
   logic [pds_pkg::FREQ_W-1:0]     best_ff, best_in;
   logic [pds_pkg::FREQ_W-1:0]     dmin_ff, dmin_in;
   logic [PW-1:0]                  bp_ff, bp_in;
   logic [FW-1:0]                  bf_ff, bf_in;
   logic [pds_pkg::POST_IDX_W-1:0] bq_ff, bq_in;

   logic                           div_start;
   logic [DW-1:0]                  div_divisor;
   logic                           div_done;
   logic [pds_pkg::FREF_W-1:0]     div_quo;
   logic                           fref_ok;
   logic                           issue;
   logic                           last_p, last_f, last_q;

   logic [19:0]                    recip_y;
   logic [40:0]                    recip_prod;
   logic [pds_pkg::FREQ_W-1:0]     fout_ext;
   logic [pds_pkg::FREQ_W-1:0]     ferr;
   logic                           take;

   assign div_start   = (state_ff == S_DIVGO);
   assign div_divisor = DW'(p_ff) + DW'(2);

   pds_divider #(
      .DIV_W(DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ref_ff),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign fref_ok = (div_quo > pds_pkg::FREF_LO) && (div_quo < pds_pkg::FREF_HI);
   assign last_p  = (p_ff == PW'(PRE_COUNT - 1));
   assign last_f  = (f_ff == FW'(FB_COUNT - 1));
   assign last_q  = (q_ff == pds_pkg::POST_DIV8);
   assign issue   = (state_ff == S_SCAN);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      ref_in    = ref_ff;
      target_in = target_ff;
      p_in      = p_ff;
      f_in      = f_ff;
      q_in      = q_ff;
      fref_in   = fref_ff;
      fvco_in   = fvco_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               ref_in    = cmd.ref_freq;
               target_in = cmd.target_freq;
               p_in      = '0;
               state_in  = S_DIVGO;
            end
         end
         S_DIVGO: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               fref_in = div_quo;
               fvco_in = VW'({div_quo, 1'b0});
               f_in    = '0;
               q_in    = pds_pkg::POST_DIV2;
               if (fref_ok) begin
                  state_in = S_SCAN;
               end else if (last_p) begin
                  state_in = S_DRAIN;
               end else begin
                  // no candidate of this prescaler can pass, skip it
                  p_in     = p_ff + 1'b1;
                  state_in = S_DIVGO;
               end
            end
         end
         S_SCAN: begin
            q_in = q_ff + 1'b1;
            if (last_q) begin
               fvco_in = fvco_ff + VW'(fref_ff);
               f_in    = f_ff + 1'b1;
               if (last_f) begin
                  if (last_p) begin
                     state_in = S_DRAIN;
                  end else begin
                     p_in     = p_ff + 1'b1;
                     state_in = S_DIVGO;
                  end
               end
            end
         end
         S_DRAIN: begin
            if (!a_valid_ff && !b_valid_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // stage B: postscale the VCO frequency
   assign recip_y    = a_fvco_ff[27:8];
   assign recip_prod = {21'b0, recip_y} * {20'b0, pds_pkg::RECIP_125};

   always_comb begin
      b_valid_in = a_valid_ff;
      b_ok_in    = (a_fvco_ff > VW'(pds_pkg::FVCO_LO)) && (a_fvco_ff < VW'(pds_pkg::FVCO_HI));
      case (a_q_ff)
         pds_pkg::POST_DIV2:     b_fout_in = a_fvco_ff[27:1];
         pds_pkg::POST_DIV4:     b_fout_in = {1'b0, a_fvco_ff[27:2]};
         pds_pkg::POST_DIV32000: b_fout_in = {13'b0, recip_prod[40:pds_pkg::RECIP_SHIFT]};
         pds_pkg::POST_DIV8:     b_fout_in = {2'b0, a_fvco_ff[27:3]};
         default:                b_fout_in = '0;
      endcase
   end

   // stage C: compare against the best so far, first strict minimum wins
   assign fout_ext = {4'b0, b_fout_ff};
   assign ferr     = (target_ff > fout_ext) ? (target_ff - fout_ext) : (fout_ext - target_ff);
   assign take     = b_valid_ff && b_ok_ff && (b_fout_ff < pds_pkg::FOUT_HI) && (ferr < dmin_ff);

   always_comb begin
      a_valid_in = issue;
      found_in   = found_ff;
      best_in    = best_ff;
      dmin_in    = dmin_ff;
      bp_in      = bp_ff;
      bf_in      = bf_ff;
      bq_in      = bq_ff;
      if (state_ff == S_IDLE && cmd.start) begin
         found_in = 1'b0;
         best_in  = pds_pkg::NO_FREQ;
         dmin_in  = pds_pkg::NO_FREQ;
         bp_in    = '0;
         bf_in    = '0;
         bq_in    = '0;
      end else if (take) begin
         found_in = 1'b1;
         best_in  = fout_ext;
         dmin_in  = ferr;
         bp_in    = b_p_ff;
         bf_in    = b_f_ff;
         bq_in    = b_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ref_ff    <= ref_in;
      target_ff <= target_in;
      p_ff      <= p_in;
      f_ff      <= f_in;
      q_ff      <= q_in;
      fref_ff   <= fref_in;
      fvco_ff   <= fvco_in;
      a_fvco_ff <= fvco_ff;
      a_p_ff    <= p_ff;
      a_f_ff    <= f_ff;
      a_q_ff    <= q_ff;
      b_ok_ff   <= b_ok_in;
      b_fout_ff <= b_fout_in;
      b_p_ff    <= a_p_ff;
      b_f_ff    <= a_f_ff;
      b_q_ff    <= a_q_ff;
      found_ff  <= found_in;
      best_ff   <= best_in;
      dmin_ff   <= dmin_in;
      bp_ff     <= bp_in;
      bf_ff     <= bf_in;
      bq_ff     <= bq_in;
   end

   assign res.done       = (state_ff == S_DONE);
   assign res.found      = found_ff;
   assign res.best_freq  = best_ff;
   assign res.pre_index  = pds_pkg::PRE_IDX_W'(bp_ff);
   assign res.fb_index   = pds_pkg::FB_IDX_W'(bf_ff);
   assign res.post_index = bq_ff;

endmodule

### design/pds_checker.sv
// Port-level checks of the PLL divider search, bound to the top level.
`include "assert_macros.svh"

module pds_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [pds_pkg::FREQ_W-1:0]     rsp_best_freq,
   input logic [pds_pkg::PRE_IDX_W-1:0]  rsp_pre_index,
   input logic [pds_pkg::FB_IDX_W-1:0]   rsp_fb_index,
   input logic [pds_pkg::POST_IDX_W-1:0] rsp_post_index,
   input logic [pds_pkg::OSC_W-1:0]      rsp_osc_select,
   input logic                           rsp_found
);

   // a stalled result word keeps valid, best frequency and osc select
   `PDS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_best_freq) && $stable(rsp_osc_select),
      "rsp word changed while stalled")

   // after an accept the block is busy
   `PDS_ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready, !req_ready,
      "req_ready high right after accept")

   // not found reports the sentinel frequency, zero indices and a PLL osc select
   `PDS_ASSERT_IMP(a_miss, clock, reset, rsp_valid && !rsp_found,
      rsp_best_freq == pds_pkg::NO_FREQ && rsp_pre_index == '0 && rsp_fb_index == '0 &&
      rsp_post_index == '0 && rsp_osc_select[0], "bad not-found result")

   // a direct match is always found
   `PDS_ASSERT_IMP(a_direct, clock, reset, rsp_valid && !rsp_osc_select[0], rsp_found,
      "direct result not flagged found")

   // a PLL setting stays below the output limit
   `PDS_ASSERT_IMP(a_fout, clock, reset, rsp_valid && rsp_found && rsp_osc_select[0],
      rsp_best_freq < {4'b0, pds_pkg::FOUT_HI}, "PLL output above limit")

endmodule

bind pll_divider_search pds_checker u_pds_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the PLL divider search: directed and random requests checked by a search model.
module tb;

   typedef struct packed {
      logic [pds_pkg::FREQ_W-1:0]     best_freq;
      logic [pds_pkg::PRE_IDX_W-1:0]  pre_index;
      logic [pds_pkg::FB_IDX_W-1:0]   fb_index;
      logic [pds_pkg::POST_IDX_W-1:0] post_index;
      logic [pds_pkg::OSC_W-1:0]      osc_select;
      logic                           found;
   } pll_setting_type;

   localparam int PRE_COUNT = 32;
   localparam int FB_COUNT  = 512;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [pds_pkg::TARGET_W-1:0]   req_target_freq;
   logic [pds_pkg::REF_W-1:0]      req_base_freq;
   logic                           req_source;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [pds_pkg::FREQ_W-1:0]     rsp_best_freq;
   logic [pds_pkg::PRE_IDX_W-1:0]  rsp_pre_index;
   logic [pds_pkg::FB_IDX_W-1:0]   rsp_fb_index;
   logic [pds_pkg::POST_IDX_W-1:0] rsp_post_index;
   logic [pds_pkg::OSC_W-1:0]      rsp_osc_select;
   logic                           rsp_found;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [pds_pkg::REF_W-1:0]      csr_frc_freq;

   logic [pds_pkg::REF_W-1:0] frc_model = pds_pkg::FRC_RESET;
   pll_setting_type           pending_settings[$];
   int                        mismatch_count = 0;
   int                        idle_max = 7;

   pll_divider_search #(
      .PRE_COUNT(PRE_COUNT),
      .FB_COUNT (FB_COUNT)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_target_freq(req_target_freq),
      .req_base_freq  (req_base_freq),
      .req_source     (req_source),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_best_freq  (rsp_best_freq),
      .rsp_pre_index  (rsp_pre_index),
      .rsp_fb_index   (rsp_fb_index),
      .rsp_post_index (rsp_post_index),
      .rsp_osc_select (rsp_osc_select),
      .rsp_found      (rsp_found),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_frc_freq   (csr_frc_freq)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Scan prescale, feedback and postscale in order; keep the first smallest error.
   function automatic pll_setting_type search_pll_setting(
      input logic [pds_pkg::TARGET_W-1:0] target,
      input logic [pds_pkg::REF_W-1:0]    base,
      input logic                         from_primary);
      longint unsigned ref_hz, fref, fvco, fout, diff, min_diff, divisor;
      int p, f, q;
      pll_setting_type best;
      ref_hz = 64'(from_primary ? base : frc_model);
      best = '0;
      best.best_freq = pds_pkg::NO_FREQ;
      if (target == ref_hz) begin
         best.best_freq  = pds_pkg::FREQ_W'(ref_hz);
         best.osc_select = from_primary ? pds_pkg::OSC_PRI : pds_pkg::OSC_FRC;
         best.found      = 1'b1;
         return best;
      end
      best.osc_select = from_primary ? pds_pkg::OSC_PRI_PLL : pds_pkg::OSC_FRC_PLL;
      min_diff = 64'h7FFF_FFFF;
      for (p = 0; p < PRE_COUNT; p++) begin
         fref = ref_hz / (p + 2);
         // drop prescalers whose reference is out of range: no candidate can pass
         if (fref <= pds_pkg::FREF_LO || fref >= pds_pkg::FREF_HI) continue;
         for (f = 0; f < FB_COUNT; f++) begin
            fvco = fref * (f + 2);
            if (fvco >= pds_pkg::FVCO_HI) break;
            if (fvco <= pds_pkg::FVCO_LO) continue;
            for (q = 0; q < 4; q++) begin
               case (pds_pkg::POST_IDX_W'(q))
                  pds_pkg::POST_DIV2:     divisor = 2;
                  pds_pkg::POST_DIV4:     divisor = 4;
                  pds_pkg::POST_DIV32000: divisor = 32000;
                  default:                divisor = 8;
               endcase
               fout = fvco / divisor;
               diff = (target > fout) ? target - fout : fout - target;
               if (diff < min_diff && fout < pds_pkg::FOUT_HI) begin
                  min_diff        = diff;
                  best.best_freq  = pds_pkg::FREQ_W'(fout);
                  best.pre_index  = pds_pkg::PRE_IDX_W'(p);
                  best.fb_index   = pds_pkg::FB_IDX_W'(f);
                  best.post_index = pds_pkg::POST_IDX_W'(q);
                  best.found      = 1'b1;
               end
            end
         end
      end
      return best;
   endfunction

   task automatic report_mismatch(input string field, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      mismatch_count++;
   endtask

   task automatic send_request(input logic [pds_pkg::TARGET_W-1:0] target,
                               input logic [pds_pkg::REF_W-1:0] base,
                               input logic from_primary);
      int gap;
      gap = $urandom_range(0, idle_max);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_target_freq = target;
      req_base_freq   = base;
      req_source      = from_primary;
      req_valid       = 1'b1;
      // hold the word until accepted
      do @(posedge clock); while (!req_ready);
      pending_settings.push_back(search_pll_setting(target, base, from_primary));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_settings.size() != 0) @(posedge clock);
   endtask

   task automatic write_frc(input logic [pds_pkg::REF_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_frc_freq = value;
      csr_valid    = 1'b1;
      do @(posedge clock); while (!csr_ready);
      frc_model = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : result_check
      int stall;
      pll_setting_type want;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = $urandom_range(0, idle_max);
         @(negedge clock);
         rsp_ready = (stall == 0);
         if (stall != 0) begin
            // stall while the word is already waiting
            do @(posedge clock); while (!rsp_valid);
            repeat (stall) @(negedge clock);
            rsp_ready = 1'b1;
         end
         do @(posedge clock); while (!rsp_valid);
         if (pending_settings.size() == 0) begin
            report_mismatch("best_freq of unrequested word", rsp_best_freq, 0);
         end else begin
            want = pending_settings.pop_front();
            if (rsp_best_freq !== want.best_freq)
               report_mismatch("best_freq", rsp_best_freq, want.best_freq);
            if (rsp_pre_index !== want.pre_index)
               report_mismatch("pre_index", rsp_pre_index, want.pre_index);
            if (rsp_fb_index !== want.fb_index)
               report_mismatch("fb_index", rsp_fb_index, want.fb_index);
            if (rsp_post_index !== want.post_index)
               report_mismatch("post_index", rsp_post_index, want.post_index);
            if (rsp_osc_select !== want.osc_select)
               report_mismatch("osc_select", rsp_osc_select, want.osc_select);
            if (rsp_found !== want.found)
               report_mismatch("found", rsp_found, want.found);
         end
      end
   end

   // Target equal to the reference bypasses the PLL.
   task automatic test_direct_match();
      send_request(pds_pkg::TARGET_W'(pds_pkg::FRC_RESET), pds_pkg::REF_W'($urandom), 1'b0);
      send_request(31'd12000000, 27'd12000000, 1'b1);
      send_request(31'd0, 27'd0, 1'b1);
      send_request(31'd134217727, 27'h7FF_FFFF, 1'b1);
   endtask

   // Each postscaler wins in its own output band.
   task automatic test_postscale_choice();
      send_request(31'd70000000, 27'd8000000, 1'b1);
      send_request(31'd40000000, 27'd8000000, 1'b1);
      send_request(31'd20000000, 27'd8000000, 1'b1);
      send_request(31'd5000, 27'd8000000, 1'b1);
      send_request(31'd0, 27'd8000000, 1'b1);
      send_request(31'h7FFF_FFFF, 27'd8000000, 1'b1);
      send_request(31'd40000000, pds_pkg::REF_W'($urandom), 1'b0);
   endtask

   // References too low for any prescaler, and the edge just above.
   task automatic test_no_setting();
      send_request(31'd10000000, 27'd1000000, 1'b1);
      send_request(31'd5, 27'd0, 1'b1);
      send_request(31'd10000000, 27'd1600000, 1'b1);
      send_request(31'd10000000, 27'd1600002, 1'b1);
   endtask

   task automatic test_frc_register();
      write_frc(27'd0);
      send_request(31'd0, pds_pkg::REF_W'($urandom), 1'b0);
      send_request(31'd1, pds_pkg::REF_W'($urandom), 1'b0);
      send_request(31'd48000000, 27'd8000000, 1'b1);
      write_frc(27'h7FF_FFFF);
      send_request(31'd60000000, pds_pkg::REF_W'($urandom), 1'b0);
      send_request(31'd134217727, 27'd0, 1'b0);
      write_frc(27'd8000000);
      send_request(31'd48000000, 27'h7FF_FFFF, 1'b0);
   endtask

   task automatic test_random_requests();
      logic [pds_pkg::REF_W-1:0]    base;
      logic [pds_pkg::TARGET_W-1:0] target;
      logic                         from_primary;
      int                           chunk;
      for (chunk = 0; chunk < 5; chunk++) begin
         idle_max = (chunk == 2) ? 0 : 7;
         if (chunk == 4)
            write_frc(pds_pkg::REF_W'($urandom));
         else
            write_frc(pds_pkg::REF_W'($urandom_range(1000000, 40000000)));
         repeat (16) begin
            from_primary = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0:       base = pds_pkg::REF_W'($urandom);
               1:       base = pds_pkg::REF_W'($urandom_range(0, 2000000));
               default: base = pds_pkg::REF_W'($urandom_range(1600000, 64000000));
            endcase
            case ($urandom_range(0, 9))
               0:       target = pds_pkg::TARGET_W'($urandom);
               1:       target = pds_pkg::TARGET_W'(from_primary ? base : frc_model);
               2:       target = pds_pkg::TARGET_W'($urandom_range(0, 10000));
               default: target = pds_pkg::TARGET_W'($urandom_range(0, 90000000));
            endcase
            send_request(target, base, from_primary);
         end
      end
      idle_max = 7;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_target_freq = '0;
      req_base_freq   = '0;
      req_source      = 1'b0;
      csr_valid       = 1'b0;
      csr_frc_freq    = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_direct_match();
      test_postscale_choice();
      test_no_setting();
      test_frc_register();
      test_random_requests();
      drain_results();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #400_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
